// File: rtl/dmc_pkg.sv
// Package for the depth-first maze carver: item structs, sequencer states,
// neighbor slot codes and the push-order permutation table.
// No dependencies.
package dmc_pkg;

    typedef struct packed {
        logic       operation;
        logic [3:0] start_row;
        logic [3:0] start_col;
        logic [4:0] shuffle_pick;
    } in_item_t;

    typedef struct packed {
        logic       carved;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic [1:0] parent_dir;
        logic [2:0] pushed_count;
        logic       done_res;
    } out_item_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    localparam logic [1:0] LAST_SLOT = 2'd3;
    localparam logic [2:0] MAX_PUSH  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_POP,
        S_LOAD,
        S_PROBE,
        S_TEST,
        S_OUT
    } state_t;

    // Push order for each pick value; bits [2i+1:2i] hold the slot pushed i-th.
    // Permutations are in lexicographic rank; picks 24..31 wrap onto 0..7.
    localparam logic [7:0] PERM_TABLE [32] = '{
        8'b11_10_01_00, 8'b10_11_01_00, 8'b11_01_10_00, 8'b01_11_10_00,
        8'b10_01_11_00, 8'b01_10_11_00, 8'b11_10_00_01, 8'b10_11_00_01,
        8'b11_00_10_01, 8'b00_11_10_01, 8'b10_00_11_01, 8'b00_10_11_01,
        8'b11_01_00_10, 8'b01_11_00_10, 8'b11_00_01_10, 8'b00_11_01_10,
        8'b01_00_11_10, 8'b00_01_11_10, 8'b10_01_00_11, 8'b01_10_00_11,
        8'b10_00_01_11, 8'b00_10_01_11, 8'b01_00_10_11, 8'b00_01_10_11,
        8'b11_10_01_00, 8'b10_11_01_00, 8'b11_01_10_00, 8'b01_11_10_00,
        8'b10_01_11_00, 8'b01_10_11_00, 8'b11_10_00_01, 8'b10_11_00_01
    };

endpackage

// File: rtl/dmc_nbr.sv
// Neighbor unit: bounds check and address step for one neighbor slot.
// Depends on dmc_pkg.
module dmc_nbr
    import dmc_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int COLS = 16
)
(
    input  logic [$clog2(ROWS)-1:0]      row,
    input  logic [$clog2(COLS)-1:0]      col,
    input  logic [$clog2(ROWS*COLS)-1:0] idx,
    input  dir_t                         slot,
    output logic                         ok,
    output logic [$clog2(ROWS)-1:0]      nb_row,
    output logic [$clog2(COLS)-1:0]      nb_col,
    output logic [$clog2(ROWS*COLS)-1:0] nb_idx,
    output logic [1:0]                   nb_dir
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int IDX_W = $clog2(ROWS*COLS);

    always_comb
    begin
        ok     = 1'b0;
        nb_row = row;
        nb_col = col;
        nb_idx = idx;
        unique case (slot)
            DIR_UP:
            begin
                ok     = (row != '0);
                nb_row = row - 1'b1;
                nb_idx = idx - IDX_W'(COLS);
            end
            DIR_DOWN:
            begin
                ok     = (row != ROW_W'(ROWS - 1));
                nb_row = row + 1'b1;
                nb_idx = idx + IDX_W'(COLS);
            end
            DIR_LEFT:
            begin
                ok     = (col != '0);
                nb_col = col - 1'b1;
                nb_idx = idx - 1'b1;
            end
            DIR_RIGHT:
            begin
                ok     = (col != COL_W'(COLS - 1));
                nb_col = col + 1'b1;
                nb_idx = idx + 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        // side of the neighbor that faces back toward this cell
        nb_dir = slot ^ 2'b01;
    end

endmodule

// File: rtl/dfs_maze_carver.sv
// Top level of the randomized depth-first maze carver: sequencer, visited
// map, pending stack and result register. Depends on dmc_pkg and dmc_nbr.
//
// Randomized depth-first maze carver over a ROWS x COLS grid. Send a start
// item (operation 0) with a start cell and a shuffle pick, then step items
// (operation 1); each item returns exactly one result. A step pops the newest
// pending cell, reports it with the side toward the cell that pushed it, and
// pushes that cell's unvisited in-range neighbors (up, down, left, right
// slots, pushed in the order the shuffle pick selects). When the stack is
// already empty, a step reports done with all other fields zero. Items are handled
// one at a time and item_stall stays high while one is in work. A step
// takes the item, reads the stack (pop, then load), probes each neighbor
// slot in turn with a test-and-push state after each in-range neighbor
// (both the visited map and the stack are single-port memories), and loads
// the result. A start item first sweeps the visited map clear, one cell a
// cycle, and then probes from the start cell. A step on an empty stack
// goes straight to loading the result. The result register frees the block
// to take the next item while a result still waits behind result_stall.
module dfs_maze_carver
    import dmc_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int COLS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int CELLS = ROWS * COLS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int IDX_W = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int ENT_W = IDX_W + ROW_W + COL_W + 2;

    // sequencer and working registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        slot_reg, slot_next;
    logic [IDX_W-1:0]  clear_reg, clear_next;
    logic [7:0]        perm_reg, perm_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [1:0]        dir_reg, dir_next;
    logic              carved_reg, carved_next;
    logic [2:0]        pushed_reg, pushed_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         res_reg, res_next;

    // neighbor latched between probe and test
    logic [ROW_W-1:0]  nrow_reg, nrow_next;
    logic [COL_W-1:0]  ncol_reg, ncol_next;
    logic [IDX_W-1:0]  nidx_reg, nidx_next;
    logic [1:0]        ndir_reg, ndir_next;

    // neighbor unit
    logic              nb_ok;
    logic [ROW_W-1:0]  nb_row;
    logic [COL_W-1:0]  nb_col;
    logic [IDX_W-1:0]  nb_idx;
    logic [1:0]        nb_dir;

    // memories
    logic              visited_mem [CELLS];
    logic [ENT_W-1:0]  stack_mem [CELLS];
    logic              vis_we, vis_re, vis_wdata;
    logic [IDX_W-1:0]  vis_addr;
    logic              vis_rd_reg;
    logic              stk_we, stk_re;
    logic [IDX_W-1:0]  stk_addr;
    logic [ENT_W-1:0]  stk_wdata;
    logic [ENT_W-1:0]  stk_rd_reg;

    logic [CNT_W-1:0]  count_m1;
    logic              stack_full;
    logic              take_item;
    logic [ROW_W-1:0]  start_row_sat;
    logic [COL_W-1:0]  start_col_sat;

    assign item_stall   = (state_reg != S_IDLE);
    assign take_item    = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = res_reg;
    assign count_m1     = count_reg - 1'b1;
    assign stack_full   = (count_reg == CNT_W'(CELLS));

    // saturate an off-grid start cell onto the last row or column
    assign start_row_sat = (32'(item.start_row) >= ROWS) ? ROW_W'(ROWS - 1)
                                                         : ROW_W'(item.start_row);
    assign start_col_sat = (32'(item.start_col) >= COLS) ? COL_W'(COLS - 1)
                                                         : COL_W'(item.start_col);

    // one shared neighbor unit, stepped through the four slots in push order
    dmc_nbr #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_nbr (
        .row    (row_reg),
        .col    (col_reg),
        .idx    (idx_reg),
        .slot   (dir_t'(perm_reg[{slot_reg, 1'b0} +: 2])),
        .ok     (nb_ok),
        .nb_row (nb_row),
        .nb_col (nb_col),
        .nb_idx (nb_idx),
        .nb_dir (nb_dir)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            slot_reg      <= '0;
            clear_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            clear_reg     <= clear_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        perm_reg   <= perm_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        idx_reg    <= idx_next;
        dir_reg    <= dir_next;
        carved_reg <= carved_next;
        pushed_reg <= pushed_next;
        res_reg    <= res_next;
        nrow_reg   <= nrow_next;
        ncol_reg   <= ncol_next;
        nidx_reg   <= nidx_next;
        ndir_reg   <= ndir_next;
    end

    // visited map: one port, read in probe, written in clear and test
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            visited_mem[vis_addr] <= vis_wdata;
        end
        if (vis_re)
        begin
            vis_rd_reg <= visited_mem[vis_addr];
        end
    end

    // pending stack: one port, read on pop, written on push
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_addr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stack_mem[stk_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        clear_next     = clear_reg;
        perm_next      = perm_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        idx_next       = idx_reg;
        dir_next       = dir_reg;
        carved_next    = carved_reg;
        pushed_next    = pushed_reg;
        res_next       = res_reg;
        nrow_next      = nrow_reg;
        ncol_next      = ncol_reg;
        nidx_next      = nidx_reg;
        ndir_next      = ndir_reg;
        out_valid_next = out_valid_reg && result_stall;

        vis_we    = 1'b0;
        vis_re    = 1'b0;
        vis_wdata = 1'b0;
        vis_addr  = nidx_reg;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_addr  = count_reg[IDX_W-1:0];
        stk_wdata = {nidx_reg, nrow_reg, ncol_reg, ndir_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (take_item)
                begin
                    perm_next   = PERM_TABLE[item.shuffle_pick];
                    slot_next   = '0;
                    pushed_next = '0;
                    carved_next = 1'b0;
                    dir_next    = '0;
                    if (item.operation == OP_START)
                    begin
                        row_next   = start_row_sat;
                        col_next   = start_col_sat;
                        idx_next   = IDX_W'(32'(start_row_sat) * COLS + 32'(start_col_sat));
                        count_next = '0;
                        clear_next = '0;
                        state_next = S_CLEAR;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty stack: report done, leave stack and map as they are
                        row_next   = '0;
                        col_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end

            S_CLEAR:
            begin
                // sweep the map, marking only the start cell
                vis_we     = 1'b1;
                vis_addr   = clear_reg;
                vis_wdata  = (clear_reg == idx_reg);
                clear_next = clear_reg + 1'b1;
                if (clear_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = S_PROBE;
                end
            end

            S_POP:
            begin
                stk_re     = 1'b1;
                stk_addr   = count_m1[IDX_W-1:0];
                count_next = count_m1;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                {idx_next, row_next, col_next, dir_next} = stk_rd_reg;
                carved_next = 1'b1;
                state_next  = S_PROBE;
            end

            S_PROBE:
            begin
                if (nb_ok)
                begin
                    vis_re     = 1'b1;
                    vis_addr   = nb_idx;
                    nrow_next  = nb_row;
                    ncol_next  = nb_col;
                    nidx_next  = nb_idx;
                    ndir_next  = nb_dir;
                    state_next = S_TEST;
                end
                else if (slot_reg == LAST_SLOT)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            S_TEST:
            begin
                if (!vis_rd_reg)
                begin
                    // mark on push so no cell is stacked twice
                    vis_we      = 1'b1;
                    vis_wdata   = 1'b1;
                    pushed_next = pushed_reg + 1'b1;
                    if (!stack_full)
                    begin
                        stk_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_PROBE;
                end
            end

            S_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !result_stall)
                begin
                    res_next.carved       = carved_reg;
                    res_next.cell_row     = 4'(row_reg);
                    res_next.cell_col     = 4'(col_reg);
                    res_next.parent_dir   = dir_reg;
                    res_next.pushed_count = pushed_reg;
                    res_next.done_res     = (count_reg == '0);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the stack never holds more entries than the grid has cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CELLS))
        else $error("stack count beyond grid size");

    // a done result leaves nothing stacked, so it cannot report pushes
    a_done_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.done_res) |-> (result.pushed_count == '0))
        else $error("done result with pushed neighbors");

    // an unvisited neighbor found in test grows the stack by one unless it is full
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST && !vis_rd_reg && !stack_full)
            |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not advance stack count");

    // a result never reports more than four pushes
    a_push_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pushed_count <= MAX_PUSH))
        else $error("pushed count above four");

endmodule
